// ----- rtl/wildcard_pattern_matcher_assert.svh -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher assertion macros
// Shared concurrent assertion forms used by the matcher RTL.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_ASSERT_SVH

// Same-cycle implication.
`define WPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Field widths, register map, input item and configuration types.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  localparam int CHAR_BITS   = 8;
  localparam int SLOT_BITS   = 6;
  localparam int LENGTH_BITS = 7;
  localparam int MATCH_BITS  = 20;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;

  localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 7'd1;
  localparam logic [CHAR_BITS-1:0]   JOKER_RESET  = 8'd63;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  typedef enum logic {
    REG_LENGTH = 1'b0,
    REG_JOKER  = 1'b1
  } reg_index_t;

  typedef struct packed {
    mode_t                mode;
    logic [SLOT_BITS-1:0] slot;
    logic [CHAR_BITS-1:0] ch;
  } item_t;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] length;
    logic [CHAR_BITS-1:0]   joker;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/wpm_cfg.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher configuration registers
// APB-style register file holding pattern length and joker code.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cfg import wpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  reg_index_t sel;
  logic       wr;

  assign sel    = reg_index_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.length <= LENGTH_RESET;
      cfg.joker  <= JOKER_RESET;
    end else if (wr) begin
      case (sel)
        REG_LENGTH: cfg.length <= pwdata[LENGTH_BITS-1:0];
        REG_JOKER:  cfg.joker  <= pwdata[CHAR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (psel && !pwrite) begin
      case (sel)
        REG_LENGTH: prdata = DATA_BITS'(cfg.length);
        REG_JOKER:  prdata = DATA_BITS'(cfg.joker);
        default:    prdata = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wpm_core.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher core
// Pattern store, text window, position counter and parallel lane compare.
// ----------------------------------------------------------------------------
`default_nettype none
`include "wildcard_pattern_matcher_assert.svh"

module wpm_core import wpm_pkg::*; #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  item_t                 item,
  input  cfg_t                  cfg,
  output logic                  hit,
  output logic [MATCH_BITS-1:0] match_start
);

  localparam int PIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW  = $clog2(MAX_PATTERN + 1);
  localparam int CW  = 34;
  localparam int WW  = MAX_PATTERN * CHAR_BITS;

  logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] pattern;
  logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] window;
  logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] win_shift;
  logic [POSITION_BITS-1:0]              pos;
  logic [POSITION_BITS-1:0]              pos_next;
  logic [LW-1:0]                         len_eff;
  logic [LW-1:0]                         sh;
  logic [WW-1:0]                         rev_flat;
  logic [WW-1:0]                         aligned;
  logic [MAX_PATTERN-1:0]                lane_ok;
  logic [CW-1:0]                         start;

  always_comb begin
    if (cfg.length == '0) begin
      len_eff = LW'(1);
    end else if (32'(cfg.length) > MAX_PATTERN) begin
      len_eff = LW'(MAX_PATTERN);
    end else begin
      len_eff = LW'(cfg.length);
    end
  end

  assign sh       = LW'(MAX_PATTERN) - len_eff;
  assign pos_next = (pos == '1) ? pos : pos + 1'b1;

  always_comb begin
    win_shift[0] = item.ch;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_shift[i] = window[i-1];
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      rev_flat[i*CHAR_BITS +: CHAR_BITS] = win_shift[MAX_PATTERN-1-i];
    end
  end

  // align newest len_eff characters so lane k faces pattern entry k
  assign aligned = rev_flat >> {sh, 3'b000};

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      lane_ok[k] = (k >= 32'(len_eff)) || (pattern[k] == cfg.joker) ||
                   (pattern[k] == aligned[k*CHAR_BITS +: CHAR_BITS]);
    end
  end

  assign hit = (item.mode == MODE_TEXT) && (CW'(pos_next) >= CW'(len_eff)) && (&lane_ok);
  assign start       = CW'(pos_next) - CW'(len_eff) + CW'(1);
  assign match_start = start[MATCH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (go && item.mode == MODE_LOAD && 32'(item.slot) < MAX_PATTERN) begin
      pattern[PIW'(item.slot)] <= item.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      pos    <= '0;
    end else if (go) begin
      case (item.mode)
        MODE_TEXT: begin
          window <= win_shift;
          pos    <= pos_next;
        end
        MODE_RESTART: begin
          window <= '0;
          pos    <= '0;
        end
        default: ;
      endcase
    end
  end

  `WPM_ASSERT_NEXT(a_pos_monotonic, clk, rst, go && item.mode == MODE_TEXT,
    pos >= $past(pos), "text position went backward")
  `WPM_ASSERT_NEXT(a_restart_clears, clk, rst, go && item.mode == MODE_RESTART,
    pos == '0, "restart did not clear text position")
  `WPM_ASSERT_NEXT(a_restart_window, clk, rst, go && item.mode == MODE_RESTART,
    window == '0, "restart did not clear text window")

endmodule

`default_nettype wire

// ----- rtl/wildcard_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// A text character is registered in the input stage, and its result in the output
// register. Throughput: one item per cycle while no stall is held, set by the single-pass
// window compare. A result held by out_stall stalls only text characters.
// Reset clears handshake state, window, position and registers; not the pattern.
// ----------------------------------------------------------------------------
`default_nettype none
`include "wildcard_pattern_matcher_assert.svh"

module wildcard_pattern_matcher import wpm_pkg::*; #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            mode,
  input  logic [SLOT_BITS-1:0]  pattern_slot,
  input  logic [CHAR_BITS-1:0]  char_code,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MATCH_BITS-1:0] match_start
);

  cfg_t                  cfg;
  item_t                 item;
  logic                  a_valid;
  logic                  a_go;
  logic                  core_hit;
  logic [MATCH_BITS-1:0] core_start;

  wpm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wpm_core #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .go          (a_go),
    .item        (item),
    .cfg         (cfg),
    .hit         (core_hit),
    .match_start (core_start)
  );

  assign a_go     = a_valid && (!out_valid || !out_stall || item.mode != MODE_TEXT);
  assign in_stall = a_valid && !a_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!a_valid || a_go) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!a_valid || a_go) begin
      item.mode <= mode_t'(mode);
      item.slot <= pattern_slot;
      item.ch   <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_go && core_hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && core_hit) begin
      match_start <= core_start;
    end
  end

  `WPM_ASSERT_NOW(a_no_overwrite, clk, rst, a_go && core_hit,
    !out_valid || !out_stall, "result overwrote a stalled transfer")
  `WPM_ASSERT_NEXT(a_result_loaded, clk, rst, a_go && core_hit,
    out_valid && match_start == $past(core_start), "result not loaded")
  `WPM_ASSERT_NOW(a_stall_busy, clk, rst, in_stall,
    a_valid, "input stalled with empty stage")

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher testbench
// Loads patterns with jokers, streams text under random idling and back
// pressure, and checks every reported match start against a predictor that
// tracks the pattern store, text window and position. It also checks the
// register port by reading each value back.
// ----------------------------------------------------------------------------
module tb;
  import wpm_pkg::*;

  localparam int MAX_PATTERN   = 64;
  localparam int POSITION_BITS = 20;
  localparam int ITEM_GOAL     = 1850;
  localparam int TAIL_ITEMS    = 200;
  localparam int HOLD_CYCLES   = 60;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int ALPHABET_SIZE = 26;
  localparam int PRINT_LIMIT   = 100;

  localparam logic [1:0]               MODE_UNUSED = 2'd3;
  localparam logic [CHAR_BITS-1:0]     LETTER_A    = 8'h41;
  localparam logic [POSITION_BITS-1:0] POS_MAX     = {POSITION_BITS{1'b1}};

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [ADDR_BITS-1:0]  paddr        = '0;
  logic [DATA_BITS-1:0]  pwdata       = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [1:0]            mode         = MODE_LOAD;
  logic [SLOT_BITS-1:0]  pattern_slot = '0;
  logic [CHAR_BITS-1:0]  char_code    = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [MATCH_BITS-1:0] match_start;

  wildcard_pattern_matcher #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(POSITION_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .pattern_slot(pattern_slot),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .match_start (match_start)
  );

  logic [CHAR_BITS-1:0]             pattern_copy [MAX_PATTERN];
  logic [MAX_PATTERN*CHAR_BITS-1:0] text_win   = '0;
  logic [POSITION_BITS-1:0]         text_pos   = '0;
  logic [LENGTH_BITS-1:0]           length_reg = LENGTH_RESET;
  logic [CHAR_BITS-1:0]             joker_reg  = JOKER_RESET;
  logic [MATCH_BITS-1:0]            expected_starts [$];
  logic [MATCH_BITS-1:0]            want_start;

  int  cycle_count     = 0;
  int  fail_count      = 0;
  int  items_sent      = 0;
  int  matches_checked = 0;
  int  reg_writes      = 0;
  bit  idle_on         = 1'b0;
  logic hold_go        = 1'b0;
  int  stall_left      = 0;
  int  hold_left       = 0;

  always #2 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= PRINT_LIMIT)
      $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  function automatic bit idle_allowed();
    return idle_on && (items_sent < ITEM_GOAL - TAIL_ITEMS);
  endfunction

  function automatic int window_length();
    if (length_reg == 0) return 1;
    if (length_reg > MAX_PATTERN) return MAX_PATTERN;
    return int'(length_reg);
  endfunction

  function automatic void advance_matcher(input logic [1:0] m, input logic [SLOT_BITS-1:0] s,
                                          input logic [CHAR_BITS-1:0] c);
    int  len;
    bit  hit;
    case (m)
      MODE_LOAD: pattern_copy[s] = c;
      MODE_RESTART: begin
        text_win = '0;
        text_pos = '0;
      end
      MODE_TEXT: begin
        text_win = {text_win[(MAX_PATTERN-1)*CHAR_BITS-1:0], c};
        if (text_pos != POS_MAX) text_pos++;
        len = window_length();
        if (text_pos >= len) begin
          hit = 1'b1;
          for (int k = 0; k < len && hit; k++) begin
            if (pattern_copy[k] != joker_reg &&
                pattern_copy[k] != text_win[(len-1-k)*CHAR_BITS +: CHAR_BITS])
              hit = 1'b0;
          end
          if (hit) expected_starts = {expected_starts, MATCH_BITS'(text_pos - len + 1)};
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_starts.size() == 0) begin
        report_mismatch($sformatf("match_start %0d with no match pending", match_start));
      end else begin
        want_start = expected_starts.pop_front();
        matches_checked++;
        if (match_start !== want_start)
          report_mismatch($sformatf("match_start %0d, want %0d", match_start, want_start));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_go) begin
        hold_left = HOLD_CYCLES;
        hold_go <= 1'b0;
      end
      if (stall_left == 0 && idle_allowed() && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 4);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [1:0] m, input logic [SLOT_BITS-1:0] s,
                           input logic [CHAR_BITS-1:0] c);
    if (idle_allowed() && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    pattern_slot <= s;
    char_code    <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_matcher(m, s, c);
    if (m != MODE_UNUSED) items_sent++;
  endtask

  task automatic send_text(input logic [CHAR_BITS-1:0] c);
    send_item(MODE_TEXT, SLOT_BITS'($urandom), c);
  endtask

  task automatic send_restart();
    send_item(MODE_RESTART, SLOT_BITS'($urandom), CHAR_BITS'($urandom));
  endtask

  task automatic send_pattern_copy(input int len);
    for (int k = 0; k < len; k++)
      send_text((pattern_copy[k] == joker_reg) ? CHAR_BITS'($urandom) : pattern_copy[k]);
  endtask

  task automatic wait_for_matches();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_starts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_starts.size() != 0) begin
      report_mismatch($sformatf("%0d match starts never arrived", expected_starts.size()));
      expected_starts.delete();
    end
  endtask

  task automatic check_reg(input reg_index_t idx);
    logic [DATA_BITS-1:0] mask;
    logic [DATA_BITS-1:0] want;
    mask = (idx == REG_LENGTH) ? DATA_BITS'({LENGTH_BITS{1'b1}}) : DATA_BITS'({CHAR_BITS{1'b1}});
    want = (idx == REG_LENGTH) ? DATA_BITS'(length_reg) : DATA_BITS'(joker_reg);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== want)
      report_mismatch($sformatf("register %s reads %0h, want %0h", idx.name(), prdata & mask,
                                want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_reg(input reg_index_t idx, input int unsigned value);
    logic [DATA_BITS-1:0] mask;
    mask = (idx == REG_LENGTH) ? DATA_BITS'({LENGTH_BITS{1'b1}}) : DATA_BITS'({CHAR_BITS{1'b1}});
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (DATA_BITS'(value) & mask) | (DATA_BITS'($urandom) & ~mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_LENGTH) length_reg = LENGTH_BITS'(value);
    else joker_reg = CHAR_BITS'(value);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_reg(idx);
  endtask

  task automatic test_directed_cases();
    check_reg(REG_LENGTH);
    check_reg(REG_JOKER);
    send_item(MODE_LOAD, 6'd0, LETTER_A);
    send_item(MODE_TEXT, 6'h3F, LETTER_A);
    send_item(MODE_TEXT, 6'd0, 8'hFF);
    send_item(MODE_TEXT, 6'd0, LETTER_A);
    send_item(MODE_UNUSED, 6'h3F, 8'hFF);
    send_item(MODE_LOAD, 6'h3F, 8'hFF);
    wait_for_matches();
    set_reg(REG_LENGTH, 0);
    send_text(LETTER_A);
    send_text(8'h00);
    send_restart();
    send_text(LETTER_A);
    wait_for_matches();
    set_reg(REG_LENGTH, 3);
    set_reg(REG_JOKER, 0);
    send_item(MODE_LOAD, 6'd1, 8'h00);
    send_item(MODE_LOAD, 6'd2, 8'hFF);
    send_restart();
    send_text(LETTER_A);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(LETTER_A);
    send_text(8'h7E);
    send_text(8'hFF);
    send_text(8'hFF);
    wait_for_matches();
  endtask

  task automatic test_full_length();
    set_reg(REG_LENGTH, 127);
    set_reg(REG_JOKER, LETTER_A + ALPHABET_SIZE - 1);
    for (int k = 0; k < MAX_PATTERN; k++)
      send_item(MODE_LOAD, SLOT_BITS'(k),
                (k % 3 == 0) ? joker_reg : LETTER_A + CHAR_BITS'($urandom_range(0, 1)));
    send_restart();
    repeat (2) begin
      send_pattern_copy(MAX_PATTERN);
      send_text(LETTER_A);
    end
    send_pattern_copy(MAX_PATTERN);
    wait_for_matches();
    set_reg(REG_LENGTH, MAX_PATTERN);
    send_pattern_copy(MAX_PATTERN);
    wait_for_matches();
    set_reg(REG_LENGTH, MAX_PATTERN + 1);
    send_restart();
    send_pattern_copy(MAX_PATTERN);
    send_pattern_copy(MAX_PATTERN);
    wait_for_matches();
  endtask

  task automatic test_back_pressure();
    idle_on = 1'b0;
    set_reg(REG_LENGTH, 6);
    set_reg(REG_JOKER, 8'hA5);
    for (int k = 0; k < 6; k++) send_item(MODE_LOAD, SLOT_BITS'(k), 8'hA5);
    send_restart();
    hold_go <= 1'b1;
    repeat (40) send_text(CHAR_BITS'($urandom));
    wait_for_matches();
  endtask

  task automatic test_random_streams();
    int len_sel;
    int eff;
    int alpha;
    int base;
    int first;
    int pick;
    int n;
    while (items_sent < ITEM_GOAL) begin
      wait_for_matches();
      idle_on = ($urandom_range(0, 3) != 0);
      len_sel = $urandom_range(0, 19);
      if (len_sel == 0) set_reg(REG_LENGTH, 0);
      else if (len_sel == 1) set_reg(REG_LENGTH, $urandom_range(MAX_PATTERN + 1, 127));
      else if (len_sel < 5) set_reg(REG_LENGTH, $urandom_range(9, MAX_PATTERN));
      else set_reg(REG_LENGTH, $urandom_range(1, 8));
      if ($urandom_range(0, 2) != 0)
        set_reg(REG_JOKER, $urandom_range(0, 1) ? int'(JOKER_RESET) : $urandom_range(0, 255));
      eff   = window_length();
      alpha = $urandom_range(1, 3);
      base  = $urandom_range(0, ALPHABET_SIZE - alpha);
      first = $urandom_range(0, eff - 1);
      for (int k = 0; k < eff; k++)
        send_item(MODE_LOAD, SLOT_BITS'((first + k) % eff),
                  ($urandom_range(0, 4) == 0) ? joker_reg
                    : LETTER_A + CHAR_BITS'(base + $urandom_range(0, alpha - 1)));
      if ($urandom_range(0, 1)) send_restart();
      n = $urandom_range(eff + 4, eff + 40);
      for (int j = 0; j < n; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) send_pattern_copy(eff);
        else if (pick < 10) send_restart();
        else if (pick < 12) send_item(MODE_UNUSED, SLOT_BITS'($urandom), CHAR_BITS'($urandom));
        else if (pick < 14)
          send_item(MODE_LOAD, SLOT_BITS'($urandom), LETTER_A + CHAR_BITS'(base));
        else if (pick < 22) send_text(CHAR_BITS'($urandom));
        else send_text(LETTER_A + CHAR_BITS'(base + $urandom_range(0, alpha - 1)));
      end
    end
    wait_for_matches();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_full_length();
    test_back_pressure();
    test_random_streams();
    $display("Run covered %0d transfers in, %0d match starts checked, %0d register writes.",
             items_sent, matches_checked, reg_writes);
    $display("Lengths zero to 127, joker patterns, all-joker windows, long holds and drains.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
